[sv/indexed_shift_list_top_macros.svh]
// Assertion macros used by the indexed shift list RTL
`ifndef INDEXED_SHIFT_LIST_TOP_MACROS_SVH
`define INDEXED_SHIFT_LIST_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ISL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a consequent in the cycle after its antecedent
`define ISL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/isl_pkg.sv]
// Types, codes and constants of the indexed shift list
package isl_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 7;
    localparam int CMP_W          = 11;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [IDX_W-1:0] CAP_RESET = 7'd64;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [IDX_W-1:0] index;
    } cell_cmd_t;

endpackage

[sv/isl_cell.sv]
// One storage cell of the shifting list
module isl_cell #(
    parameter int ELEM_WIDTH = isl_pkg::ELEM_WIDTH_DEF,
    parameter int POS        = 0
) (
    input  logic                  clk,
    input  isl_pkg::cell_cmd_t    cmd,
    input  logic [ELEM_WIDTH-1:0] new_data,
    input  logic [ELEM_WIDTH-1:0] left_data,
    input  logic [ELEM_WIDTH-1:0] right_data,
    output logic [ELEM_WIDTH-1:0] data
);

    localparam int CW = isl_pkg::CMP_W;
    localparam logic [CW-1:0] POS_V = CW'(POS);

    logic [CW-1:0]         idx_ext;
    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    assign idx_ext = CW'(cmd.index);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            if (POS_V == idx_ext)
            begin
                data_next = new_data;
            end
            else if (POS_V > idx_ext)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.shift_down)
        begin
            if (POS_V >= idx_ext)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/indexed_shift_list_top.sv]
// Indexed shift list: bounded ordered list held in a row of shifting cells
//
// Input transactions (s_*) carry an action in s_tuser and an index plus an
// element value in s_tdata: clear, insert at index, remove at index or read
// at index. Each accepted transaction yields exactly one output transaction
// (m_*) with the status in m_tuser and read data, element count, full and
// empty flags in m_tdata.
// The result is registered: it appears in the output register at the edge
// after acceptance. Throughput is one transaction per cycle while the output
// is not stalled, set by the row of cells, which shifts the elements at and above the index together.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled receiver holds the result and stops intake until it is taken.
// The APB port writes the capacity register (offset 0); values of 0 act as
// 1 and values above the cell count act as the cell count.
// Reset empties the list, sets capacity to 64 and drops any pending result.
// Cell contents are not cleared; only positions below the count are read.
`include "indexed_shift_list_top_macros.svh"

module indexed_shift_list_top #(
    parameter int DEPTH      = isl_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = isl_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // index[6:0], elem_data[38:7], zero
    input  logic [1:0]                    s_tuser,  // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // read_data[31:0], count[38:32],
                                                    // is_full[39], is_empty[40], zero
    output logic [1:0]                    m_tuser   // status[1:0]
);

    localparam int IW = isl_pkg::IDX_W;
    localparam int DW = isl_pkg::DATA_W;
    localparam int CW = isl_pkg::CMP_W;
    localparam int CAP_LIM = (DEPTH < (2 ** IW) - 1) ? DEPTH : (2 ** IW) - 1;
    localparam logic [IW-1:0] CAP_LIM_V = IW'(CAP_LIM);

    logic [IW-1:0]          capacity_reg;
    logic [IW-1:0]          count_reg;
    logic [IW-1:0]          count_next;
    logic                   m_valid_reg;
    isl_pkg::status_t       status_reg;
    isl_pkg::status_t       status_next;
    logic [DW-1:0]          rdata_reg;
    logic [DW-1:0]          rdata_next;
    logic                   full_reg;
    logic                   empty_reg;

    logic                   acc;
    logic                   cfg_wr;
    isl_pkg::action_t       act;
    logic [IW-1:0]          idx;
    logic [DW-1:0]          elem_in;
    logic [IW-1:0]          eff_cap;
    logic                   ins_ok;
    logic                   rem_ok;
    isl_pkg::cell_cmd_t     cmd;
    logic [ELEM_WIDTH-1:0]  new_elem;
    logic [ELEM_WIDTH-1:0]  rd_bus;
    logic [DW-1:0]          rd_ext;
    logic [CW-1:0]          idx_ext;
    logic [ELEM_WIDTH-1:0]  cell_data [DEPTH];

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == isl_pkg::REG_CAPACITY);
    assign prdata   = (paddr[2] == isl_pkg::REG_CAPACITY)
                      ? {{(32 - IW){1'b0}}, capacity_reg} : 32'd0;

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign act      = isl_pkg::action_t'(s_tuser);
    assign idx      = s_tdata[IW-1:0];
    assign elem_in  = s_tdata[IW+DW-1:IW];
    assign idx_ext  = CW'(idx);

    assign eff_cap  = (capacity_reg == '0) ? IW'(1)
                      : ((capacity_reg > CAP_LIM_V) ? CAP_LIM_V : capacity_reg);

    generate
        if (ELEM_WIDTH <= DW)
        begin : g_narrow
            assign new_elem = elem_in[ELEM_WIDTH-1:0];
            assign rd_ext   = {{(DW - ELEM_WIDTH){1'b0}}, rd_bus};
        end
        else
        begin : g_wide
            assign new_elem = {{(ELEM_WIDTH - DW){1'b0}}, elem_in};
            assign rd_ext   = rd_bus[DW-1:0];
        end
    endgenerate

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) == idx_ext)
            begin
                rd_bus = rd_bus | cell_data[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = isl_pkg::ST_OK;
        rdata_next  = '0;
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        unique case (act)
            isl_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            isl_pkg::ACT_INSERT:
            begin
                if (idx > count_reg)
                begin
                    status_next = isl_pkg::ST_INVALID;
                end
                else if (count_reg >= eff_cap)
                begin
                    status_next = isl_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + IW'(1);
                end
            end
            isl_pkg::ACT_REMOVE:
            begin
                if (idx >= count_reg)
                begin
                    status_next = isl_pkg::ST_INVALID;
                end
                else
                begin
                    rem_ok     = 1'b1;
                    count_next = count_reg - IW'(1);
                end
            end
            isl_pkg::ACT_READ:
            begin
                if (idx >= count_reg)
                begin
                    status_next = isl_pkg::ST_INVALID;
                end
                else
                begin
                    rdata_next = rd_ext;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign cmd.shift_up   = acc && ins_ok;
    assign cmd.shift_down = acc && rem_ok;
    assign cmd.index      = idx;

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [ELEM_WIDTH-1:0] left_w;
            logic [ELEM_WIDTH-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = new_elem;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            isl_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .POS        (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .new_data   (new_elem),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= isl_pkg::CAP_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                capacity_reg <= pwdata[IW-1:0];
            end
            if (acc)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            full_reg   <= (count_next >= eff_cap);
            empty_reg  <= (count_next == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, empty_reg, full_reg, count_reg, rdata_reg};

    `ISL_ASSERT_NEXT(a_clear_empties, acc && (act == isl_pkg::ACT_CLEAR), count_reg == '0)
    `ISL_ASSERT_NEXT(a_insert_grows, acc && ins_ok, count_reg == $past(count_reg) + IW'(1))
    `ISL_ASSERT_NOW(a_full_status, acc && (status_next == isl_pkg::ST_FULL),
                    count_reg >= eff_cap)
    `ISL_ASSERT_NOW(a_count_bound, m_valid_reg, count_reg <= CAP_LIM_V)

endmodule
